FILE: sv/pidfd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and microcode ROM for the filtered-derivative PID block.
// No dependencies; imported by every other module of the block.
package pidfd_pkg;

  localparam int DATA_WIDTH_DEF    = 32;
  localparam int FRAC_BITS_DEF     = 16;
  localparam int DERIV_ON_MEAS_DEF = 0;

  localparam int IO_W       = 32;               // width of all stream fields
  localparam int ALPHA_BITS = 16;               // alpha is unsigned Q1.16
  localparam int ALPHA_W    = ALPHA_BITS + 1;   // 65536 must fit
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_BITS;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [IO_W-1:0] LIM_LO_RST = {1'b1, {(IO_W-1){1'b0}}};
  localparam logic [IO_W-1:0] LIM_HI_RST = {1'b0, {(IO_W-1){1'b1}}};

  typedef enum logic [2:0] {
    REG_KP         = 3'd0,
    REG_KI_DT      = 3'd1,
    REG_KD_OVER_DT = 3'd2,
    REG_ALPHA      = 3'd3,
    REG_INTEG_MIN  = 3'd4,
    REG_INTEG_MAX  = 3'd5,
    REG_OUT_MIN    = 3'd6,
    REG_OUT_MAX    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [IO_W-1:0]    kp;
    logic [IO_W-1:0]    ki_dt;
    logic [IO_W-1:0]    kd_over_dt;
    logic [ALPHA_W-1:0] alpha;
    logic [IO_W-1:0]    integ_min;
    logic [IO_W-1:0]    integ_max;
    logic [IO_W-1:0]    out_min;
    logic [IO_W-1:0]    out_max;
  } cfg_t;

  // microcode fields
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LO,
    MUL_HI
  } mul_op_t;

  typedef enum logic [1:0] {
    MS_KI,
    MS_ALPHA,
    MS_KP,
    MS_KD
  } mul_src_t;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_ERR,
    ALU_DIFF,
    ALU_INTEG_ADD,
    ALU_INTEG_CLAMP,
    ALU_FILT_SUB,
    ALU_FILT_ADD,
    ALU_PI_ADD,
    ALU_D_ADD,
    ALU_FINISH,
    ALU_CLEAR
  } alu_op_t;

  typedef enum logic {
    JC_NONE,
    JC_KI_ZERO
  } jcond_t;

  typedef logic [3:0] upc_t;

  localparam upc_t UPC_COMPUTE = 4'd0;
  localparam upc_t UPC_FILTER  = 4'd5;
  localparam upc_t UPC_CLEAR   = 4'd14;

  typedef struct packed {
    mul_op_t  mul_op;
    mul_src_t mul_src;
    alu_op_t  alu_op;
    jcond_t   jcond;
    upc_t     target;
    logic     last;
    logic     emit;
  } ctrl_t;

  typedef struct packed {
    logic  load;   // latch a new input transaction
    logic  exec;   // current control word takes effect this cycle
    logic  emit;   // drive result goes to the output register
    ctrl_t cw;
  } dp_ctl_t;

  typedef struct packed {
    logic ki_zero;
  } dp_sts_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  function automatic ctrl_t uword(mul_op_t m, mul_src_t s, alu_op_t o, jcond_t j,
                                  upc_t t, logic l, logic e);
    ctrl_t w;
    w = '{m, s, o, j, t, l, e};
    return w;
  endfunction

  // Control program. Multiplies take a low-half and a high-half step; the
  // product is used by the ALU in the step after the high half.
  function automatic ctrl_t ucode_rom(upc_t a);
    ctrl_t w;
    case (a)
      4'd0:  w = uword(MUL_NONE, MS_KI,    ALU_ERR,         JC_NONE,    UPC_COMPUTE, 1'b0, 1'b0);
      4'd1:  w = uword(MUL_LO,   MS_KI,    ALU_DIFF,        JC_KI_ZERO, UPC_FILTER,  1'b0, 1'b0);
      4'd2:  w = uword(MUL_HI,   MS_KI,    ALU_NOP,         JC_NONE,    UPC_COMPUTE, 1'b0, 1'b0);
      4'd3:  w = uword(MUL_NONE, MS_KI,    ALU_INTEG_ADD,   JC_NONE,    UPC_COMPUTE, 1'b0, 1'b0);
      4'd4:  w = uword(MUL_NONE, MS_KI,    ALU_INTEG_CLAMP, JC_NONE,    UPC_COMPUTE, 1'b0, 1'b0);
      4'd5:  w = uword(MUL_NONE, MS_ALPHA, ALU_FILT_SUB,    JC_NONE,    UPC_COMPUTE, 1'b0, 1'b0);
      4'd6:  w = uword(MUL_LO,   MS_ALPHA, ALU_NOP,         JC_NONE,    UPC_COMPUTE, 1'b0, 1'b0);
      4'd7:  w = uword(MUL_HI,   MS_ALPHA, ALU_NOP,         JC_NONE,    UPC_COMPUTE, 1'b0, 1'b0);
      4'd8:  w = uword(MUL_LO,   MS_KP,    ALU_FILT_ADD,    JC_NONE,    UPC_COMPUTE, 1'b0, 1'b0);
      4'd9:  w = uword(MUL_HI,   MS_KP,    ALU_NOP,         JC_NONE,    UPC_COMPUTE, 1'b0, 1'b0);
      4'd10: w = uword(MUL_LO,   MS_KD,    ALU_PI_ADD,      JC_NONE,    UPC_COMPUTE, 1'b0, 1'b0);
      4'd11: w = uword(MUL_HI,   MS_KD,    ALU_NOP,         JC_NONE,    UPC_COMPUTE, 1'b0, 1'b0);
      4'd12: w = uword(MUL_NONE, MS_KD,    ALU_D_ADD,       JC_NONE,    UPC_COMPUTE, 1'b0, 1'b0);
      4'd13: w = uword(MUL_NONE, MS_KD,    ALU_FINISH,      JC_NONE,    UPC_COMPUTE, 1'b1, 1'b1);
      4'd14: w = uword(MUL_NONE, MS_KI,    ALU_CLEAR,       JC_NONE,    UPC_COMPUTE, 1'b1, 1'b0);
      default: w = uword(MUL_NONE, MS_KI,  ALU_NOP,         JC_NONE,    UPC_COMPUTE, 1'b1, 1'b0);
    endcase
    return w;
  endfunction

endpackage

FILE: sv/pidfd_mul.sv
`timescale 1ns / 1ps
// Shared two-step multiplier: low half of b, then high half with accumulate.
// Output is the product shifted right (floor) and saturated. Uses pidfd_pkg.
module pidfd_mul #(
  parameter int W         = 32,
  parameter int AW        = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  pidfd_pkg::mul_op_t      mul_op,
  input  logic signed [AW-1:0]    a,
  input  logic signed [W-1:0]     b,
  input  logic                    sh_alpha,
  output logic signed [W-1:0]     p
);
  import pidfd_pkg::*;

  localparam int HW  = W / 2;
  localparam int BHW = W - HW;
  localparam int PW  = AW + W;
  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

  logic signed [HW:0]        b_lo;
  logic signed [BHW-1:0]     b_hi;
  logic signed [AW+HW:0]     prod_lo;
  logic signed [AW+BHW-1:0]  prod_hi;
  logic signed [PW-1:0]      plo_r, plo_nxt;
  logic signed [PW-1:0]      acc_r, acc_nxt;
  logic                      sha_r, sha_nxt;
  logic signed [PW-1:0]      shv;
  logic                      in_range;

  assign b_lo    = $signed({1'b0, b[HW-1:0]});
  assign b_hi    = b[W-1:HW];
  assign prod_lo = a * b_lo;
  assign prod_hi = a * b_hi;

  always_comb begin
    plo_nxt = plo_r;
    acc_nxt = acc_r;
    sha_nxt = sha_r;
    case (mul_op)
      MUL_LO: begin
        plo_nxt = PW'(prod_lo);
      end
      MUL_HI: begin
        acc_nxt = (PW'(prod_hi) <<< HW) + plo_r;
        sha_nxt = sh_alpha;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    plo_r <= plo_nxt;
    acc_r <= acc_nxt;
    sha_r <= sha_nxt;
  end

  assign shv      = sha_r ? (acc_r >>> ALPHA_BITS) : (acc_r >>> FRAC_BITS);
  assign in_range = (&shv[PW-1:W-1]) | ~(|shv[PW-1:W-1]);
  assign p        = in_range ? shv[W-1:0] : (shv[PW-1] ? MINW : MAXW);

endmodule

FILE: sv/pidfd_dp.sv
`timescale 1ns / 1ps
// Datapath: controller state, saturating ALU and the shared multiplier.
// Driven by one control word per cycle from pidfd_seq. Uses pidfd_pkg, pidfd_mul.
module pidfd_dp #(
  parameter int W                    = 32,
  parameter int FRAC_BITS            = 16,
  parameter int DERIV_ON_MEASUREMENT = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pidfd_pkg::dp_ctl_t          ctl,
  input  pidfd_pkg::cfg_t             cfg,
  input  logic [pidfd_pkg::IO_W-1:0]  setpoint,
  input  logic [pidfd_pkg::IO_W-1:0]  measurement,
  output pidfd_pkg::dp_sts_t          sts,
  output logic signed [W-1:0]         drive
);
  import pidfd_pkg::*;

  localparam int AW = (W > ALPHA_W) ? W : ALPHA_W + 1;
  localparam int EW = (W > IO_W) ? W : IO_W;
  localparam logic [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] to_w(input logic [IO_W-1:0] v);
    logic signed [EW-1:0] e;
    logic                 ok;
    e  = EW'($signed(v));
    ok = (&e[EW-1:W-1]) | ~(|e[EW-1:W-1]);
    return ok ? e[W-1:0] : (e[EW-1] ? MINW : MAXW);
  endfunction

  function automatic logic signed [W-1:0] sat1(input logic signed [W:0] s);
    return (s[W] == s[W-1]) ? s[W-1:0] : (s[W] ? MINW : MAXW);
  endfunction

  function automatic logic signed [W-1:0] add_sat(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
    logic signed [W:0] s;
    s = (W+1)'(x) + (W+1)'(y);
    return sat1(s);
  endfunction

  function automatic logic signed [W-1:0] sub_sat(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
    logic signed [W:0] s;
    s = (W+1)'(x) - (W+1)'(y);
    return sat1(s);
  endfunction

  // upper limit tested first, as required when limits cross
  function automatic logic signed [W-1:0] clamp(input logic signed [W-1:0] v,
                                                input logic signed [W-1:0] lo,
                                                input logic signed [W-1:0] hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  logic signed [W-1:0] kp_w, ki_w, kd_w, imin_w, imax_w, omin_w, omax_w;
  logic [ALPHA_W-1:0]  alpha_eff;
  logic signed [AW-1:0] mul_a;
  logic signed [W-1:0]  mul_b;
  logic signed [W-1:0]  prod;
  mul_op_t              mul_op;

  logic signed [W-1:0] sp_r, sp_nxt, meas_r, meas_nxt, err_r, err_nxt;
  logic signed [W-1:0] t_r, t_nxt, s_r, s_nxt;
  logic signed [W-1:0] integ_r, integ_nxt, filt_r, filt_nxt;
  logic signed [W-1:0] last_err_r, last_err_nxt, last_meas_r, last_meas_nxt;

  assign kp_w      = to_w(cfg.kp);
  assign ki_w      = to_w(cfg.ki_dt);
  assign kd_w      = to_w(cfg.kd_over_dt);
  assign imin_w    = to_w(cfg.integ_min);
  assign imax_w    = to_w(cfg.integ_max);
  assign omin_w    = to_w(cfg.out_min);
  assign omax_w    = to_w(cfg.out_max);
  assign alpha_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;

  assign sts.ki_zero = (ki_w == '0);

  always_comb begin
    case (ctl.cw.mul_src)
      MS_KI: begin
        mul_a = AW'(ki_w);
        mul_b = err_r;
      end
      MS_ALPHA: begin
        mul_a = $signed(AW'(alpha_eff));
        mul_b = t_r;
      end
      MS_KP: begin
        mul_a = AW'(kp_w);
        mul_b = err_r;
      end
      default: begin
        mul_a = AW'(kd_w);
        mul_b = filt_r;
      end
    endcase
  end

  assign mul_op = ctl.exec ? ctl.cw.mul_op : MUL_NONE;

  pidfd_mul #(
    .W         (W),
    .AW        (AW),
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk      (clk),
    .mul_op   (mul_op),
    .a        (mul_a),
    .b        (mul_b),
    .sh_alpha (ctl.cw.mul_src == MS_ALPHA),
    .p        (prod)
  );

  always_comb begin
    sp_nxt        = sp_r;
    meas_nxt      = meas_r;
    err_nxt       = err_r;
    t_nxt         = t_r;
    s_nxt         = s_r;
    integ_nxt     = integ_r;
    filt_nxt      = filt_r;
    last_err_nxt  = last_err_r;
    last_meas_nxt = last_meas_r;
    if (ctl.load) begin
      sp_nxt   = to_w(setpoint);
      meas_nxt = to_w(measurement);
    end else if (ctl.exec) begin
      unique case (ctl.cw.alu_op)
        ALU_ERR:         err_nxt = sub_sat(sp_r, meas_r);
        ALU_DIFF: begin
          if (DERIV_ON_MEASUREMENT != 0) t_nxt = sub_sat(last_meas_r, meas_r);
          else                           t_nxt = sub_sat(err_r, last_err_r);
        end
        ALU_INTEG_ADD:   s_nxt     = add_sat(integ_r, prod);
        ALU_INTEG_CLAMP: integ_nxt = clamp(s_r, imin_w, imax_w);
        ALU_FILT_SUB:    t_nxt     = sub_sat(t_r, filt_r);
        ALU_FILT_ADD:    filt_nxt  = add_sat(filt_r, prod);
        ALU_PI_ADD:      s_nxt     = add_sat(prod, integ_r);
        ALU_D_ADD:       s_nxt     = add_sat(s_r, prod);
        ALU_FINISH: begin
          last_err_nxt  = err_r;
          last_meas_nxt = meas_r;
        end
        ALU_CLEAR: begin
          integ_nxt     = '0;
          filt_nxt      = '0;
          last_err_nxt  = '0;
          last_meas_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      filt_r      <= '0;
      last_err_r  <= '0;
      last_meas_r <= '0;
    end else begin
      integ_r     <= integ_nxt;
      filt_r      <= filt_nxt;
      last_err_r  <= last_err_nxt;
      last_meas_r <= last_meas_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sp_r   <= sp_nxt;
    meas_r <= meas_nxt;
    err_r  <= err_nxt;
    t_r    <= t_nxt;
    s_r    <= s_nxt;
  end

  assign drive = clamp(s_r, omin_w, omax_w);

endmodule

FILE: sv/pidfd_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, ROM lookup, conditional jump, handshake.
// Uses pidfd_pkg (control word types and ROM).
module pidfd_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_cmd,
  input  logic                out_busy,
  input  pidfd_pkg::dp_sts_t  sts,
  output logic                in_ready,
  output pidfd_pkg::dp_ctl_t  ctl
);
  import pidfd_pkg::*;

  seq_state_t state_r, state_nxt;
  upc_t       pc_r, pc_nxt;
  ctrl_t      cw;
  logic       go;
  logic       taken;

  assign cw    = ucode_rom(pc_r);
  // an emitting step waits until the output register is free
  assign go    = !(cw.emit && out_busy);
  assign taken = (cw.jcond == JC_KI_ZERO) && sts.ki_zero;

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          pc_nxt    = in_cmd ? UPC_CLEAR : UPC_COMPUTE;
        end
      end
      ST_RUN: begin
        if (go) begin
          if (cw.last) state_nxt = ST_IDLE;
          pc_nxt = taken ? cw.target : pc_r + upc_t'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl.load = 1'b0;
    ctl.exec = 1'b0;
    ctl.emit = 1'b0;
    ctl.cw   = cw;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_RUN: begin
        ctl.exec = go;
        ctl.emit = go && cw.emit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= UPC_COMPUTE;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

FILE: sv/pid_controller_filtered_derivative.sv
`timescale 1ns / 1ps
// PID controller with integrator clamp and low-pass filtered derivative.
// Top level: config registers, output register, sequencer and datapath.
// Depends on pidfd_pkg, pidfd_seq, pidfd_dp (and pidfd_mul below it).
//
// Usage:
//   in_*  : one transaction per control sample. tuser = command (0 compute,
//           1 clear state); tdata = setpoint (low word), measurement (high word).
//   out_* : one drive value per compute transaction; a clear gives none.
//   cfg_* : APB-style register port, registers at byte address 4*index.
//           Write registers only while no transaction is in flight.
// Sequencing:
//   A compute transaction runs a 14-step microprogram (with ki_dt zero the
//   integrator update is jumped over); its last step puts the drive value in
//   the output register. The next transaction is accepted only once the block
//   is idle again, so only one is in flight. A clear runs only the clear step.
//   The one shared multiplier computes four products of two half-width steps
//   each.
// Reset (synchronous, rst_n low): state and registers return to defaults,
//   output empty, block ready for input.
// Back-pressure: the result waits in the output register; a following item is
//   still accepted and computed, and its last step holds until that register
//   is free.
module pid_controller_filtered_derivative #(
  parameter int DERIV_ON_MEASUREMENT = pidfd_pkg::DERIV_ON_MEAS_DEF,
  parameter int DATA_WIDTH           = pidfd_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS            = pidfd_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input stream
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [2*pidfd_pkg::IO_W-1:0]          in_tdata,  // [31:0] setpoint, [63:32] measurement
  input  logic [0:0]                            in_tuser,  // [0] command
  // result stream
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pidfd_pkg::IO_W-1:0]            out_tdata, // [31:0] drive
  // register port
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [pidfd_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [pidfd_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [pidfd_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                  cfg_pready
);
  import pidfd_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  cfg_idx_t cfg_idx;
  logic     cfg_wr;

  dp_ctl_t  ctl;
  dp_sts_t  sts;
  logic signed [DATA_WIDTH-1:0] drive;

  logic            out_tvalid_r, out_tvalid_nxt;
  logic [IO_W-1:0] out_tdata_r, out_tdata_nxt;

  // ---------------- register port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KP:         cfg_nxt.kp         = cfg_pwdata;
        REG_KI_DT:      cfg_nxt.ki_dt      = cfg_pwdata;
        REG_KD_OVER_DT: cfg_nxt.kd_over_dt = cfg_pwdata;
        REG_ALPHA:      cfg_nxt.alpha      = cfg_pwdata[ALPHA_W-1:0];
        REG_INTEG_MIN:  cfg_nxt.integ_min  = cfg_pwdata;
        REG_INTEG_MAX:  cfg_nxt.integ_max  = cfg_pwdata;
        REG_OUT_MIN:    cfg_nxt.out_min    = cfg_pwdata;
        REG_OUT_MAX:    cfg_nxt.out_max    = cfg_pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_KP:         cfg_prdata = cfg_r.kp;
      REG_KI_DT:      cfg_prdata = cfg_r.ki_dt;
      REG_KD_OVER_DT: cfg_prdata = cfg_r.kd_over_dt;
      REG_ALPHA:      cfg_prdata = CFG_DATA_W'(cfg_r.alpha);
      REG_INTEG_MIN:  cfg_prdata = cfg_r.integ_min;
      REG_INTEG_MAX:  cfg_prdata = cfg_r.integ_max;
      REG_OUT_MIN:    cfg_prdata = cfg_r.out_min;
      REG_OUT_MAX:    cfg_prdata = cfg_r.out_max;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp         <= '0;
      cfg_r.ki_dt      <= '0;
      cfg_r.kd_over_dt <= '0;
      cfg_r.alpha      <= ALPHA_ONE;
      cfg_r.integ_min  <= LIM_LO_RST;
      cfg_r.integ_max  <= LIM_HI_RST;
      cfg_r.out_min    <= LIM_LO_RST;
      cfg_r.out_max    <= LIM_HI_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- control and datapath ----------------
  pidfd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_cmd   (in_tuser[0]),
    .out_busy (out_tvalid_r && !out_tready),
    .sts      (sts),
    .in_ready (in_tready),
    .ctl      (ctl)
  );

  pidfd_dp #(
    .W                    (DATA_WIDTH),
    .FRAC_BITS            (FRAC_BITS),
    .DERIV_ON_MEASUREMENT (DERIV_ON_MEASUREMENT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .cfg         (cfg_r),
    .setpoint    (in_tdata[IO_W-1:0]),
    .measurement (in_tdata[2*IO_W-1:IO_W]),
    .sts         (sts),
    .drive       (drive)
  );

  // ---------------- output register ----------------
  // drive carries the low 32 bits of the (sign-extended) result
  assign out_tvalid_nxt = ctl.emit ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);
  assign out_tdata_nxt  = ctl.emit ? IO_W'(drive) : out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else        out_tvalid_r <= out_tvalid_nxt;
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: sv/pidfd_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the PID block, attached to the top level by bind.
// Depends on pidfd_pkg and pid_controller_filtered_derivative.
module pidfd_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic [0:0]                            in_tuser,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [pidfd_pkg::IO_W-1:0]            out_tdata
);
  import pidfd_pkg::*;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // reset empties the output and leaves the block ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

  // only one transaction in flight
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted while a transaction is in flight");

  // a clear command gives no result
  a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser[0] && !out_tvalid |=> !out_tvalid)
    else $error("result produced by a clear command");

  // no compute result appears right after acceptance
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_tuser[0] && !out_tvalid |=> !out_tvalid ##1 !out_tvalid)
    else $error("result appeared too early");

endmodule

bind pid_controller_filtered_derivative pidfd_chk u_pidfd_chk (.*);

FILE: test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pid_controller_filtered_derivative: a scoreboard class
// predicts each drive value, plain tasks drive the stream and APB-style ports.
// Depends on pidfd_pkg and the RTL of the block.

typedef enum bit {
  CMD_COMPUTE = 1'b0,
  CMD_CLEAR   = 1'b1
} pid_cmd_t;

// Tracks controller state and registers; holds the drive values still due.
class pid_step_tracker;
  typedef logic signed [127:0] wide_t;

  localparam int     DW     = pidfd_pkg::DATA_WIDTH_DEF;
  localparam int     FB     = pidfd_pkg::FRAC_BITS_DEF;
  localparam bit     ON_MEAS = pidfd_pkg::DERIV_ON_MEAS_DEF != 0;
  localparam longint Q_MAX  = (longint'(1) <<< (DW - 1)) - 1;
  localparam longint Q_MIN  = -Q_MAX - 1;
  localparam longint A_ONE  = longint'(1) <<< pidfd_pkg::ALPHA_BITS;

  longint gain_p, gain_i, gain_d, alpha_w;
  longint integ_lo, integ_hi, drive_lo, drive_hi;
  longint integ_acc, prev_err, prev_meas, filt_diff;
  logic [31:0] drive_due[$];
  int errors;

  function new();
    gain_p    = 0;
    gain_i    = 0;
    gain_d    = 0;
    alpha_w   = A_ONE;
    integ_lo  = from32(32'h8000_0000);
    integ_hi  = from32(32'h7FFF_FFFF);
    drive_lo  = integ_lo;
    drive_hi  = integ_hi;
    integ_acc = 0;
    prev_err  = 0;
    prev_meas = 0;
    filt_diff = 0;
    errors    = 0;
  endfunction

  function longint fit(wide_t x);
    if (x > wide_t'(Q_MAX)) return Q_MAX;
    if (x < wide_t'(Q_MIN)) return Q_MIN;
    return longint'(x);
  endfunction

  function longint from32(logic [31:0] v);
    return fit(longint'($signed(v)));
  endfunction

  // max is tested first, so crossed limits favor max
  function longint limit(longint v, longint lo, longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // exact product, floor shift, then saturate
  function longint fmul(longint a, longint b, int sh);
    wide_t p;
    p = a;
    p = p * b;
    return fit(p >>> sh);
  endfunction

  function void set_reg(pidfd_pkg::cfg_idx_t idx, logic [31:0] v);
    case (idx)
      pidfd_pkg::REG_KP:         gain_p   = from32(v);
      pidfd_pkg::REG_KI_DT:      gain_i   = from32(v);
      pidfd_pkg::REG_KD_OVER_DT: gain_d   = from32(v);
      pidfd_pkg::REG_ALPHA:      alpha_w  = longint'(v[pidfd_pkg::ALPHA_W-1:0]);
      pidfd_pkg::REG_INTEG_MIN:  integ_lo = from32(v);
      pidfd_pkg::REG_INTEG_MAX:  integ_hi = from32(v);
      pidfd_pkg::REG_OUT_MIN:    drive_lo = from32(v);
      default:                   drive_hi = from32(v);
    endcase
  endfunction

  function void take_sample(pid_cmd_t cmd, logic [31:0] sp_raw, logic [31:0] ms_raw);
    longint sp, ms, e, d, a, f, dr;
    if (cmd == CMD_CLEAR) begin
      integ_acc = 0;
      prev_err  = 0;
      prev_meas = 0;
      filt_diff = 0;
      return;
    end
    sp = from32(sp_raw);
    ms = from32(ms_raw);
    e  = fit(sp - ms);
    if (gain_i != 0)
      integ_acc = limit(fit(integ_acc + fmul(gain_i, e, FB)), integ_lo, integ_hi);
    d  = ON_MEAS ? fit(prev_meas - ms) : fit(e - prev_err);
    a  = (alpha_w > A_ONE) ? A_ONE : alpha_w;
    f  = fit(filt_diff + fmul(a, fit(d - filt_diff), pidfd_pkg::ALPHA_BITS));
    dr = fit(fmul(gain_p, e, FB) + integ_acc);
    dr = fit(dr + fmul(gain_d, f, FB));
    dr = limit(dr, drive_lo, drive_hi);
    prev_err  = e;
    prev_meas = ms;
    filt_diff = f;
    drive_due.push_back(dr[31:0]);
  endfunction

  function void check_drive(logic [31:0] got);
    logic [31:0] want;
    if (drive_due.size() == 0) begin
      $error("drive: expected none, got %0d", $signed(got));
      errors++;
      return;
    end
    want = drive_due.pop_front();
    if (got !== want) begin
      $error("drive: expected %0d, got %0d", $signed(want), $signed(got));
      errors++;
    end
  endfunction

  function int pending();
    return drive_due.size();
  endfunction
endclass

module tb;
  import pidfd_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 7;
  // long enough for a compute or a clear still in flight to finish
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 150;
  // slowest plausible run is about 1.1 ms; keep a wide margin
  localparam int RUN_LIMIT_NS  = 12_000_000;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [2*IO_W-1:0]     in_tdata    = '0;   // [31:0] setpoint, [63:32] measurement
  logic [0:0]            in_tuser    = '0;   // [0] command
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [IO_W-1:0]       out_tdata;          // [31:0] drive
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  pid_step_tracker trk = new();

  pid_controller_filtered_derivative dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 0;
  end

  // Receiver back-pressure: runs of always-ready, coin-flip, hard stall and a
  // one-in-three pattern, each run of random length.
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(1, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= 1'b0;
      default: out_tready <= (rx_tick % 3 == 0);
    endcase
    rx_tick <= rx_tick + 1;
  end

  // Transaction monitor: both sides sampled on the edge that completes the
  // handshake, values seen are the ones held before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        trk.take_sample(pid_cmd_t'(in_tuser[0]), in_tdata[31:0], in_tdata[63:32]);
      if (out_tvalid && out_tready)
        trk.check_drive(out_tdata);
    end
  end

  // Present one input transaction and hold it until accepted. tvalid stays
  // high on return so back-to-back items need no extra edge.
  task automatic send_item(pid_cmd_t cmd, logic [31:0] sp, logic [31:0] ms);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {ms, sp};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic idle_gap(int unsigned n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop tvalid, wait until every drive has come back, then let the block
  // finish any clear still in flight.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (trk.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle, access cycle, then an idle cycle so psel never toggles
  // twice in one step between writes
  task automatic cfg_write(cfg_idx_t idx, logic [31:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    trk.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic load_regs(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                           logic [31:0] al, logic [31:0] imin, logic [31:0] imax,
                           logic [31:0] omin, logic [31:0] omax);
    cfg_write(REG_KP, kp);
    cfg_write(REG_KI_DT, ki);
    cfg_write(REG_KD_OVER_DT, kd);
    cfg_write(REG_ALPHA, al);
    cfg_write(REG_INTEG_MIN, imin);
    cfg_write(REG_INTEG_MAX, imax);
    cfg_write(REG_OUT_MIN, omin);
    cfg_write(REG_OUT_MAX, omax);
  endtask

  // mostly plant-sized values (+-100.0), sometimes the rails or anything
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000;
    endcase
  endfunction

  // gains mostly within +-4.0
  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return $urandom;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  // upper register bits are don't-care; weights above one act as one
  function automatic logic [31:0] rand_alpha();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'(ALPHA_ONE);
      2:       return $urandom_range(32'h1_0001, 32'h1_FFFF);
      3:       return $urandom;
      default: return $urandom_range(0, 32'(ALPHA_ONE));
    endcase
  endfunction

  function automatic logic [31:0] rand_level();
    if ($urandom_range(0, 3) == 0)
      return $urandom;
    return $urandom_range(0, 32'h0258_0000) - 32'h012C_0000;
  endfunction

  // ordered pair most of the time; sometimes crossed, sometimes the full range
  task automatic rand_limits(output logic [31:0] lo, output logic [31:0] hi);
    logic [31:0] a, b;
    a = rand_level();
    b = rand_level();
    case ($urandom_range(0, 5))
      0: begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end
      1: begin
        lo = ($signed(a) > $signed(b)) ? a : b;
        hi = ($signed(a) > $signed(b)) ? b : a;
      end
      default: begin
        lo = ($signed(a) < $signed(b)) ? a : b;
        hi = ($signed(a) < $signed(b)) ? b : a;
      end
    endcase
  endtask

  task automatic phase_regs(int p);
    logic [31:0] ilo, ihi, olo, ohi;
    rand_limits(ilo, ihi);
    rand_limits(olo, ohi);
    case (p)
      // every gain on a rail, no filtering weight at all
      0: load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      // integrator frozen, derivative unfiltered
      1: load_regs(32'h8000_0000, '0, 32'h8000_0000, 32'(ALPHA_ONE), ilo, ihi, olo, ohi);
      default: load_regs(rand_gain(), rand_gain(), rand_gain(), rand_alpha(),
                         ilo, ihi, olo, ohi);
    endcase
  endtask

  // Random control traffic: the measurement drifts toward or away from a held
  // setpoint, with setpoint steps, clears and raw noise mixed in. Sent in
  // bursts with random gaps between them.
  task automatic run_phase(int n);
    logic [31:0] sp_now, ms_now;
    int unsigned burst_left, r;
    sp_now     = rand_sample();
    ms_now     = rand_sample();
    burst_left = 0;
    for (int i = 0; i < n; i++) begin
      if (burst_left == 0) begin
        idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
        burst_left = $urandom_range(1, 24);
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_item(CMD_CLEAR, $urandom, $urandom);
      end else if (r < 15) begin
        sp_now = rand_sample();
        send_item(CMD_COMPUTE, sp_now, ms_now);
      end else if (r < 25) begin
        send_item(CMD_COMPUTE, $urandom, $urandom);
      end else begin
        ms_now = ms_now + ($urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
        send_item(CMD_COMPUTE, sp_now, ms_now);
      end
      burst_left--;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values: all gains zero, so the drive must be zero.
    send_item(CMD_COMPUTE, 32'h0012_3456, 32'hFFFE_0000);
    send_item(CMD_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_drained();

    // Unit-ish gains, weight register above one, integrator held to +-10.0.
    load_regs(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_FFFF,
              32'hFFF6_0000, 32'h000A_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_COMPUTE, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_COMPUTE, 32'h7FFF_FFFF, 32'h8000_0000);  // error saturates high
    send_item(CMD_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF);  // error saturates low
    send_item(CMD_COMPUTE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(CMD_COMPUTE, 32'h8000_0000, 32'h8000_0000);
    send_item(CMD_COMPUTE, 32'h0001_0000, 32'h0000_0000);
    send_item(CMD_COMPUTE, 32'h0000_0000, 32'h0001_0000);
    send_item(CMD_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF);  // data ignored
    send_item(CMD_COMPUTE, 32'h0005_0000, 32'h0002_0000);  // history starts fresh
    send_item(CMD_COMPUTE, 32'hFFFF_FFFF, 32'h0000_0000);
    wait_drained();

    // Crossed limits on both the integrator and the output.
    load_regs(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000,
              32'h0005_0000, 32'hFFFB_0000, 32'h0003_0000, 32'hFFFD_0000);
    send_item(CMD_COMPUTE, 32'h0000_0000, 32'h0000_0000);
    send_item(CMD_COMPUTE, 32'h0002_0000, 32'h0000_0000);
    send_item(CMD_COMPUTE, 32'h0000_0000, 32'h0002_0000);
    send_item(CMD_COMPUTE, 32'h0010_0000, 32'h0000_0000);
    send_item(CMD_COMPUTE, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(CMD_CLEAR,   32'h0000_0000, 32'h0000_0000);
    send_item(CMD_COMPUTE, 32'h0000_0000, 32'h0000_0000);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      phase_regs(p);
      run_phase(PHASE_ITEMS);
      wait_drained();
    end

    if (trk.errors == 0 && trk.pending() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: done, errors");
    $finish;
  end
endmodule

FILE: pid_controller_filtered_derivative.f
sv/pidfd_pkg.sv
sv/pidfd_mul.sv
sv/pidfd_dp.sv
sv/pidfd_seq.sv
sv/pid_controller_filtered_derivative.sv
sv/pidfd_chk.sv
test/tb.sv
